/* rtl/nvcp_pkg.sv */
package nvcp_pkg;

   // Message and name limits
   localparam int MAX_MSG_LEN = 64;
   localparam int NAME_LEN    = 8;
   localparam int NUM_NAMES   = 6;

   // Register file layout: six 64-bit name slots, then the names-in-use count
   localparam int NUM_SLOTS   = 6;
   localparam int SLOT_W      = 64;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int REG_IDX_W   = 3;
   localparam int NIU_W       = 3;

   localparam logic [REG_IDX_W-1:0] REG_NAME_SLOT_0 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_NAME_SLOT_5 = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_NAMES_IN_USE = 3'd6;

   // Counter widths
   localparam int NAME_POS_W = $clog2(NAME_LEN + 1);
   localparam int BYTE_CNT_W = $clog2(MAX_MSG_LEN + 1);
   localparam int FRAC_W     = 7;

   // Configuration handed from the register file to the parser
   typedef struct packed {
      logic [NUM_SLOTS-1:0][SLOT_W-1:0] slot;
      logic [NIU_W-1:0]                 names_in_use;
   } cfg_type;

   // Pick byte pos of a packed name, first character in the low byte
   function automatic logic [7:0] slot_byte(input logic [SLOT_W-1:0] name,
                                            input logic [2:0] pos);
      slot_byte = name[{pos, 3'b000} +: 8];
   endfunction

endpackage

/* rtl/nvcp_regs.sv */
module nvcp_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [nvcp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [nvcp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [nvcp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output nvcp_pkg::cfg_type                 cfg
);

   nvcp_pkg::cfg_type              cfg_ff, cfg_in;
   logic [nvcp_pkg::REG_IDX_W-1:0] reg_idx;
   logic                           wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[nvcp_pkg::CSR_ADDR_W-1:3];
   assign wr_en   = psel && penable && pwrite;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         if (reg_idx <= nvcp_pkg::REG_NAME_SLOT_5) begin
            cfg_in.slot[reg_idx] = pwdata;
         end else if (reg_idx == nvcp_pkg::REG_NAMES_IN_USE) begin
            cfg_in.names_in_use = pwdata[nvcp_pkg::NIU_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read decode
   always_comb begin
      unique case (reg_idx) inside
         [nvcp_pkg::REG_NAME_SLOT_0:nvcp_pkg::REG_NAME_SLOT_5]: prdata = cfg_ff.slot[reg_idx];
         nvcp_pkg::REG_NAMES_IN_USE: prdata = nvcp_pkg::CSR_DATA_W'(cfg_ff.names_in_use);
         default: prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/name_value_command_parser_top.sv */
// Parses name=value# text messages arriving one byte per word on req_. A new byte can
// be accepted on every clock while req_ready is high; the name compare and the
// multiply-by-ten accumulate that update the parse state are combinational. The last
// word (req_last_byte set) produces one result, registered and shown on rsp_ the next
// cycle; while it waits for rsp_ready, req_ready is low. The user must write name slots
// and names_in_use over the APB port only while no message is in flight (unchecked).
module name_value_command_parser_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // byte input
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_last_byte,
   // result output
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic [2:0]                           rsp_slot_index,
   output logic signed [31:0]                   rsp_mantissa,
   output logic [6:0]                           rsp_decimal_places,
   output logic                                 rsp_overflow,
   // configuration
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [nvcp_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [nvcp_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [nvcp_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   localparam logic [1:0] PH_NAME   = 2'd0;
   localparam logic [1:0] PH_VFIRST = 2'd1;
   localparam logic [1:0] PH_VALUE  = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [nvcp_pkg::FRAC_W-1:0] FRAC_MAX = '1;
   localparam logic signed [31:0] ACC_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] ACC_MIN = 32'sh80000000;
   localparam logic signed [36:0] T_MAX   = 37'sd2147483647;
   localparam logic signed [36:0] T_MIN   = -37'sd2147483648;

   nvcp_pkg::cfg_type cfg;

   nvcp_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // parse state
   logic [1:0]                        phase_ff, phase_in;
   logic [nvcp_pkg::NAME_POS_W-1:0]   name_pos_ff, name_pos_in;
   logic [nvcp_pkg::NUM_SLOTS-1:0]    match_ff, match_in;
   logic [nvcp_pkg::BYTE_CNT_W-1:0]   byte_cnt_ff, byte_cnt_in;
   logic signed [31:0]                acc_ff, acc_in;
   logic                              sat_ff, sat_in;
   logic                              neg_ff, neg_in;
   logic                              dot_ff, dot_in;
   logic [nvcp_pkg::FRAC_W-1:0]       frac_ff, frac_in;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              found_ff, found_in;
   logic [2:0]                        slot_idx_ff, slot_idx_in;
   logic signed [31:0]                mant_ff, mant_in;
   logic [6:0]                        dec_ff, dec_in;
   logic                              ovf_ff, ovf_in;

   logic                              req_fire;
   logic [nvcp_pkg::NUM_SLOTS-1:0]    eq_at_pos, nz_at_pos, nz_at_next;
   logic [nvcp_pkg::NUM_SLOTS-1:0]    match_close, used_mask;
   logic [nvcp_pkg::NIU_W-1:0]        used;
   logic signed [36:0]                acc_x, acc_t;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // per-slot byte compares at the current and next name position
   always_comb begin
      for (int s = 0; s < nvcp_pkg::NUM_SLOTS; s++) begin
         eq_at_pos[s]  = nvcp_pkg::slot_byte(cfg.slot[s], 3'(name_pos_ff)) == req_data_byte;
         nz_at_pos[s]  = nvcp_pkg::slot_byte(cfg.slot[s], 3'(name_pos_ff)) != CH_NUL;
         nz_at_next[s] = nvcp_pkg::slot_byte(cfg.slot[s], 3'(name_pos_in)) != CH_NUL;
      end
   end

   // times ten plus (byte - '0')
   assign acc_x = 37'(acc_ff);
   assign acc_t = (acc_x <<< 3) + (acc_x <<< 1) + $signed({29'b0, req_data_byte})
                  - $signed({29'b0, CH_ZERO});

   // next parse state for one word
   always_comb begin
      logic do_value;
      do_value    = 1'b0;
      phase_in    = phase_ff;
      name_pos_in = name_pos_ff;
      match_in    = match_ff;
      byte_cnt_in = byte_cnt_ff;
      acc_in      = acc_ff;
      sat_in      = sat_ff;
      neg_in      = neg_ff;
      dot_in      = dot_ff;
      frac_in     = frac_ff;
      if (req_fire && byte_cnt_ff < nvcp_pkg::BYTE_CNT_W'(nvcp_pkg::MAX_MSG_LEN)) begin
         byte_cnt_in = byte_cnt_ff + 1'b1;
         unique case (phase_ff)
            PH_NAME: begin
               if (req_data_byte == CH_EQ || req_data_byte == CH_NUL) begin
                  if (name_pos_ff < nvcp_pkg::NAME_POS_W'(nvcp_pkg::NAME_LEN)) begin
                     match_in = match_ff & ~nz_at_pos;
                  end
                  phase_in = PH_VFIRST;
               end else if (name_pos_ff < nvcp_pkg::NAME_POS_W'(nvcp_pkg::NAME_LEN)) begin
                  match_in    = match_ff & eq_at_pos;
                  name_pos_in = name_pos_ff + 1'b1;
               end else begin
                  match_in = '0;
               end
            end
            PH_VFIRST: begin
               phase_in = PH_VALUE;
               if (req_data_byte == CH_MINUS) begin
                  neg_in = 1'b1;
               end else begin
                  do_value = 1'b1;
               end
            end
            PH_VALUE: do_value = 1'b1;
            PH_DONE: ;
            default: ;
         endcase
      end
      // value characters
      if (do_value) begin
         if (req_data_byte == CH_HASH || req_data_byte == CH_NUL) begin
            phase_in = PH_DONE;
         end else if (req_data_byte == CH_DOT) begin
            dot_in  = 1'b1;
            frac_in = '0;
         end else begin
            if (dot_ff && frac_ff < FRAC_MAX) begin
               frac_in = frac_ff + 1'b1;
            end
            if (!sat_ff) begin
               if (acc_t > T_MAX) begin
                  acc_in = ACC_MAX;
                  sat_in = 1'b1;
               end else if (acc_t < T_MIN) begin
                  acc_in = ACC_MIN;
                  sat_in = 1'b1;
               end else begin
                  acc_in = acc_t[31:0];
               end
            end
         end
      end
   end

   // end of message: close a name still open, pick the lowest matching slot
   always_comb begin
      match_close = match_in;
      if (phase_in == PH_NAME && name_pos_in < nvcp_pkg::NAME_POS_W'(nvcp_pkg::NAME_LEN)) begin
         match_close = match_in & ~nz_at_next;
      end
      used = (cfg.names_in_use > nvcp_pkg::NIU_W'(nvcp_pkg::NUM_NAMES)) ?
             nvcp_pkg::NIU_W'(nvcp_pkg::NUM_NAMES) : cfg.names_in_use;
      for (int s = 0; s < nvcp_pkg::NUM_SLOTS; s++) begin
         used_mask[s] = nvcp_pkg::NIU_W'(s) < used;
      end
      found_in    = 1'b0;
      slot_idx_in = '0;
      for (int s = nvcp_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
         if (match_close[s] && used_mask[s]) begin
            found_in    = 1'b1;
            slot_idx_in = 3'(s);
         end
      end
      mant_in = '0;
      dec_in  = '0;
      ovf_in  = 1'b0;
      if (found_in) begin
         dec_in = frac_in;
         ovf_in = sat_in;
         if (neg_in) begin
            if (acc_in == ACC_MIN) begin
               mant_in = ACC_MAX;
               ovf_in  = 1'b1;
            end else begin
               mant_in = -acc_in;
            end
         end else begin
            mant_in = acc_in;
         end
      end
   end

   // output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire && req_last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NAME;
         name_pos_ff  <= '0;
         match_ff     <= '1;
         byte_cnt_ff  <= '0;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         neg_ff       <= 1'b0;
         dot_ff       <= 1'b0;
         frac_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire && req_last_byte) begin
            phase_ff    <= PH_NAME;
            name_pos_ff <= '0;
            match_ff    <= '1;
            byte_cnt_ff <= '0;
            acc_ff      <= '0;
            sat_ff      <= 1'b0;
            neg_ff      <= 1'b0;
            dot_ff      <= 1'b0;
            frac_ff     <= '0;
         end else begin
            phase_ff    <= phase_in;
            name_pos_ff <= name_pos_in;
            match_ff    <= match_in;
            byte_cnt_ff <= byte_cnt_in;
            acc_ff      <= acc_in;
            sat_ff      <= sat_in;
            neg_ff      <= neg_in;
            dot_ff      <= dot_in;
            frac_ff     <= frac_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_fire && req_last_byte) begin
         found_ff    <= found_in;
         slot_idx_ff <= slot_idx_in;
         mant_ff     <= mant_in;
         dec_ff      <= dec_in;
         ovf_ff      <= ovf_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = found_ff;
   assign rsp_slot_index     = slot_idx_ff;
   assign rsp_mantissa       = mant_ff;
   assign rsp_decimal_places = dec_ff;
   assign rsp_overflow       = ovf_ff;

   // a final word always leaves a fresh parse state behind
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte |=>
         phase_ff == PH_NAME && byte_cnt_ff == '0 && match_ff == '1)
      else $error("parse state not cleared after final word");

   // byte counter never runs past the message limit
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      byte_cnt_ff <= nvcp_pkg::BYTE_CNT_W'(nvcp_pkg::MAX_MSG_LEN))
      else $error("byte counter beyond message limit");

   // a miss carries an all-zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |->
         rsp_mantissa == '0 && rsp_decimal_places == '0 && !rsp_overflow
         && rsp_slot_index == '0)
      else $error("payload not zero on a miss");

   // a hit names a slot index below NUM_NAMES
   a_hit_in_use: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_slot_index < nvcp_pkg::NIU_W'(nvcp_pkg::NUM_NAMES))
      else $error("slot index out of range");

endmodule
